/* rtl/sots6_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sots6_pkg: shared constants for the sum-of-two-sixth-powers test
// Holds the base limit register format and the seeds of the forward
// difference engine that fills the sixth-power table.
// ----------------------------------------------------------------------------
package sots6_pkg;

    // Width of the base limit configuration word and its value after reset.
    localparam int unsigned LIMIT_W     = 13;
    localparam int unsigned LIMIT_RESET = 2000;

    // Order of the difference engine: x^6 has a constant sixth difference.
    localparam int unsigned DIFF_ORDER = 6;

    // Forward differences of f(x) = x^6 taken at x = 1, from f(1) up to the
    // constant sixth difference 6! = 720.
    localparam int unsigned DIFF_SEED [0:DIFF_ORDER] = '{1, 63, 602, 2100, 3360, 2520, 720};

endpackage

/* rtl/sum_of_two_sixth_powers_test.sv */
`timescale 1ns / 1ps
// One search step per cycle over the table's two read ports; a new input
// word is accepted only once the result of the last one has been moved
// into the output register. Reset: synchronous active-low; the base limit
// returns to 2000 (capped at MAX_BASE) and the table is refilled, during
// which no input word is accepted. Configuration writes are taken at any
// time.
// ----------------------------------------------------------------------------
// sum_of_two_sixth_powers_test: top level
// Answers whether a 128-bit target is x^6 + y^6 with 1 <= x, y <= limit,
// searching a table of sixth powers with two pointers.
// ----------------------------------------------------------------------------
module sum_of_two_sixth_powers_test #(
    parameter int unsigned MAX_BASE = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sots6_pkg::LIMIT_W-1:0]      cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [63:0]                        s_target_low,
    input  logic [63:0]                        s_target_high,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_found
);

    localparam int unsigned LW     = $clog2(MAX_BASE + 1);
    localparam int unsigned AW     = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;
    localparam int unsigned PW     = 6 * LW;
    localparam int unsigned CMPW   = (LW > sots6_pkg::LIMIT_W) ? LW : sots6_pkg::LIMIT_W;
    localparam int unsigned LIM_RV = (sots6_pkg::LIMIT_RESET > MAX_BASE) ?
                                     MAX_BASE : sots6_pkg::LIMIT_RESET;

    logic [LW-1:0]   limit_reg, limit_next;
    logic [CMPW-1:0] cfg_ext;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [PW-1:0]   wr_data;
    logic            fill_done;
    logic [AW-1:0]   rd_addr_x;
    logic [AW-1:0]   rd_addr_y;
    logic [PW-1:0]   rd_data_x;
    logic [PW-1:0]   rd_data_y;

    // Base limit register, saturated at the built maximum on write.
    assign cfg_ready = 1'b1;
    assign cfg_ext   = CMPW'(cfg_data);

    always_comb begin
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_ext > CMPW'(MAX_BASE)) begin
                limit_next = LW'(MAX_BASE);
            end else begin
                limit_next = LW'(cfg_ext);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LW'(LIM_RV);
        end else begin
            limit_reg <= limit_next;
        end
    end

    // Table fill after reset.
    sots6_fill #(
        .MAX_BASE (MAX_BASE),
        .AW       (AW),
        .PW       (PW)
    ) u_fill (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .fill_done (fill_done)
    );

    // Sixth-power table.
    sots6_table #(
        .DEPTH (MAX_BASE),
        .AW    (AW),
        .PW    (PW)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_x (rd_addr_x),
        .rd_addr_y (rd_addr_y),
        .rd_data_x (rd_data_x),
        .rd_data_y (rd_data_y)
    );

    // Two-pointer search and the handshakes.
    sots6_walk #(
        .LW (LW),
        .AW (AW),
        .PW (PW)
    ) u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .table_ready   (fill_done),
        .limit         (limit_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_target_low  (s_target_low),
        .s_target_high (s_target_high),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .rd_addr_x     (rd_addr_x),
        .rd_addr_y     (rd_addr_y),
        .rd_data_x     (rd_data_x),
        .rd_data_y     (rd_data_y)
    );

endmodule

/* rtl/sots6_fill.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sots6_fill: sixth-power table fill engine
// After reset, writes x^6 for x = 1..MAX_BASE into the table, one entry a
// cycle, using a chain of forward difference accumulators (adds only).
// ----------------------------------------------------------------------------
module sots6_fill #(
    parameter int unsigned MAX_BASE = 4096,
    parameter int unsigned AW       = 12,
    parameter int unsigned PW       = 78
) (
    input  logic          aclk,
    input  logic          aresetn,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [PW-1:0] wr_data,
    output logic          fill_done
);

    localparam int unsigned ORD = sots6_pkg::DIFF_ORDER;

    logic [PW-1:0] diff_reg [0:ORD-1];
    logic [AW-1:0] idx_reg;
    logic          busy_reg;
    logic          last_entry;

    assign last_entry = (idx_reg == AW'(MAX_BASE - 1));

    // Difference chain: every accumulator adds the next higher difference.
    // All arithmetic wraps at PW bits, which keeps the written value exact.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ORD; k++) begin
                diff_reg[k] <= PW'(sots6_pkg::DIFF_SEED[k]);
            end
            idx_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            for (int k = 0; k < ORD - 1; k++) begin
                diff_reg[k] <= diff_reg[k] + diff_reg[k+1];
            end
            diff_reg[ORD-1] <= diff_reg[ORD-1] + PW'(sots6_pkg::DIFF_SEED[ORD]);
            idx_reg <= idx_reg + AW'(1);
            if (last_entry) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign wr_en     = busy_reg;
    assign wr_addr   = idx_reg;
    assign wr_data   = diff_reg[0];
    assign fill_done = ~busy_reg;

endmodule

/* rtl/sots6_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sots6_table: sixth-power table memory
// One write port and two read ports with registered read data; entry i
// holds (i+1)^6.
// ----------------------------------------------------------------------------
module sots6_table #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12,
    parameter int unsigned PW    = 78
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [PW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr_x,
    input  logic [AW-1:0] rd_addr_y,
    output logic [PW-1:0] rd_data_x,
    output logic [PW-1:0] rd_data_y
);

    logic [PW-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports with registered read data.
    always_ff @(posedge aclk) begin
        rd_data_x <= mem[rd_addr_x];
        rd_data_y <= mem[rd_addr_y];
    end

endmodule

/* rtl/sots6_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sots6_walk: two-pointer search over the sixth-power table
// x rises from 1 and y falls from the limit; each search cycle compares
// x^6 + y^6 against the target and either ends the search or moves one
// pointer, issuing the reads for the next pair in the same cycle.
// ----------------------------------------------------------------------------
module sots6_walk #(
    parameter int unsigned LW = 13,
    parameter int unsigned AW = 12,
    parameter int unsigned PW = 78
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          table_ready,
    input  logic [LW-1:0] limit,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [63:0]   s_target_low,
    input  logic [63:0]   s_target_high,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_found,
    output logic [AW-1:0] rd_addr_x,
    output logic [AW-1:0] rd_addr_y,
    input  logic [PW-1:0] rd_data_x,
    input  logic [PW-1:0] rd_data_y
);

    localparam int unsigned PTW = LW + 1;
    localparam int unsigned SW  = PW + 1;
    localparam int unsigned CW  = (SW > 128) ? SW : 128;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } walk_state_t;

    walk_state_t    state_reg, state_next;
    logic [PTW-1:0] x_reg, x_next;
    logic [PTW-1:0] y_reg, y_next;
    logic [127:0]   target_reg, target_next;
    logic           hit_reg, hit_next;
    logic           m_valid_reg;
    logic           found_reg;

    logic           in_accept;
    logic           out_free;
    logic [CW-1:0]  pair_sum;
    logic [CW-1:0]  target_ext;
    logic           sum_eq;
    logic           sum_lt;
    logic [PTW-1:0] addr_x_full;
    logic [PTW-1:0] addr_y_full;

    assign s_ready   = table_ready && (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // Sum of the two table words against the zero-extended target.
    assign pair_sum   = CW'(rd_data_x) + CW'(rd_data_y);
    assign target_ext = CW'(target_reg);
    assign sum_eq     = (pair_sum == target_ext);
    assign sum_lt     = (pair_sum < target_ext);

    // Pointer update; the table is addressed by the pointers' next values so
    // that the read data lines up with the registered pointers.
    always_comb begin
        state_next  = state_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        target_next = target_reg;
        hit_next    = hit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    target_next = {s_target_high, s_target_low};
                    x_next      = PTW'(1);
                    y_next      = PTW'(limit);
                    hit_next    = 1'b0;
                    if (limit == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (x_reg > y_reg) begin
                    hit_next   = 1'b0;
                    state_next = ST_DONE;
                end else if (sum_eq) begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (sum_lt) begin
                    x_next = x_reg + PTW'(1);
                end else begin
                    y_next = y_reg - PTW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign addr_x_full = x_next - PTW'(1);
    assign addr_y_full = y_next - PTW'(1);
    assign rd_addr_x   = addr_x_full[AW-1:0];
    assign rd_addr_y   = addr_y_full[AW-1:0];

    // State, pointers and the output word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            x_reg       <= '0;
            y_reg       <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            hit_reg   <= hit_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                found_reg   <= hit_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Target word; no reset needed.
    always_ff @(posedge aclk) begin
        target_reg <= target_next;
    end

    assign m_valid = m_valid_reg;
    assign m_found = found_reg;

endmodule
